// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, clocked on aclk and muted while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain check, sampled at the rising clock edge
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition must never hold
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

// ----- rtl/ksa_pkg.sv -----
// ---------------------------------------------------------------------------
// ksa_pkg
// Types and constants shared by the knob setpoint adjuster modules.
// ---------------------------------------------------------------------------
`default_nettype none

package ksa_pkg;

    // Item kinds on the input stream (tuser)
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_EDGE = 1'b1;

    // Knob direction
    localparam logic DIR_INC = 1'b0;
    localparam logic DIR_DEC = 1'b1;

    // Quantity selector on the input
    localparam logic [1:0] MODE_SPEED_A = 2'd0;
    localparam logic [1:0] MODE_SPEED_B = 2'd1;
    localparam logic [1:0] MODE_TEMP    = 2'd2;
    localparam logic [1:0] MODE_TIME    = 2'd3;

    // Quantity code on the result stream
    typedef enum logic [1:0] {
        QTY_SPEED = 2'd0,
        QTY_TEMP  = 2'd1,
        QTY_TIME  = 2'd2
    } quantity_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SPEED_MAX      = 3'd0,
        REG_SPEED_MIN      = 3'd1,
        REG_TEMP_MAX       = 3'd2,
        REG_TEMP_MIN       = 3'd3,
        REG_TIME_MAX       = 3'd4,
        REG_TIME_MIN       = 3'd5,
        REG_FAST_THRESHOLD = 3'd6
    } cfg_reg_t;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LIMIT_W    = 16;
    localparam int RATE_W     = 8;
    localparam int TICK_W     = 7;

    // Register reset values
    localparam logic [LIMIT_W-1:0] RST_SPEED_MAX = 16'd1500;
    localparam logic [LIMIT_W-1:0] RST_SPEED_MIN = 16'd100;
    localparam logic [LIMIT_W-1:0] RST_TEMP_MAX  = 16'd3500;
    localparam logic [LIMIT_W-1:0] RST_TEMP_MIN  = 16'd0;
    localparam logic [LIMIT_W-1:0] RST_TIME_MAX  = 16'd35940;
    localparam logic [LIMIT_W-1:0] RST_TIME_MIN  = 16'd0;
    localparam logic [RATE_W-1:0]  RST_FAST_THR  = 8'd10;

    // Step sizes and special values
    localparam logic [LIMIT_W-1:0] STEP_SPEED_FINE   = 16'd10;
    localparam logic [LIMIT_W-1:0] STEP_SPEED_COARSE = 16'd30;
    localparam logic [LIMIT_W-1:0] STEP_TEMP_LOW     = 16'd5;
    localparam logic [LIMIT_W-1:0] STEP_TEMP_HIGH    = 16'd10;
    localparam logic [LIMIT_W-1:0] STEP_TEMP_COARSE  = 16'd20;
    localparam logic [LIMIT_W-1:0] STEP_TIME_FINE    = 16'd60;
    localparam logic [LIMIT_W-1:0] STEP_TIME_COARSE  = 16'd300;
    localparam logic [LIMIT_W-1:0] SPEED_JUMP        = 16'd100;
    localparam logic [LIMIT_W-1:0] TEMP_BREAK        = 16'd1000;

    localparam logic [RATE_W-1:0] EDGE_COUNT_MAX = 8'd255;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [LIMIT_W-1:0] speed_ceil;
        logic [LIMIT_W-1:0] speed_floor;
        logic [LIMIT_W-1:0] temp_ceil;
        logic [LIMIT_W-1:0] temp_floor;
        logic [LIMIT_W-1:0] dur_ceil;
        logic [LIMIT_W-1:0] dur_floor;
        logic [RATE_W-1:0]  fast_threshold;
    } ksa_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/ksa_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// ksa_cfg_regs
// Write-only configuration register file: clamps and the fast threshold.
// ---------------------------------------------------------------------------
`default_nettype none

module ksa_cfg_regs
    import ksa_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output ksa_cfg_t                   cfg
);

    ksa_cfg_t cfg_reg;
    ksa_cfg_t cfg_next;

    // Address decode; indexes past the list are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_SPEED_MAX:      cfg_next.speed_ceil     = cfg_wdata;
                REG_SPEED_MIN:      cfg_next.speed_floor    = cfg_wdata;
                REG_TEMP_MAX:       cfg_next.temp_ceil      = cfg_wdata;
                REG_TEMP_MIN:       cfg_next.temp_floor     = cfg_wdata;
                REG_TIME_MAX:       cfg_next.dur_ceil       = cfg_wdata;
                REG_TIME_MIN:       cfg_next.dur_floor      = cfg_wdata;
                REG_FAST_THRESHOLD: cfg_next.fast_threshold = cfg_wdata[RATE_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed_ceil     <= RST_SPEED_MAX;
            cfg_reg.speed_floor    <= RST_SPEED_MIN;
            cfg_reg.temp_ceil      <= RST_TEMP_MAX;
            cfg_reg.temp_floor     <= RST_TEMP_MIN;
            cfg_reg.dur_ceil       <= RST_TIME_MAX;
            cfg_reg.dur_floor      <= RST_TIME_MIN;
            cfg_reg.fast_threshold <= RST_FAST_THR;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/ksa_rate_meter.sv -----
// ---------------------------------------------------------------------------
// ksa_rate_meter
// Counts knob edges and latches the count as the rate once per tick window.
// ---------------------------------------------------------------------------
`default_nettype none

module ksa_rate_meter
    import ksa_pkg::*;
#(
    parameter int TICKS_PER_WINDOW = 100
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              tick_en,
    input  wire logic              edge_en,
    output logic [RATE_W-1:0]      knob_rate
);

    localparam logic [TICK_W:0] WINDOW_END = (TICK_W+1)'(TICKS_PER_WINDOW);

    logic [TICK_W-1:0] tick_count_reg, tick_count_next;
    logic [RATE_W-1:0] edge_count_reg, edge_count_next;
    logic [RATE_W-1:0] knob_rate_reg,  knob_rate_next;
    logic [TICK_W:0]   tick_inc;

    // Window counter and edge counter update
    always_comb begin
        tick_count_next = tick_count_reg;
        edge_count_next = edge_count_reg;
        knob_rate_next  = knob_rate_reg;
        tick_inc        = {1'b0, tick_count_reg} + 1'b1;
        if (tick_en) begin
            if (tick_inc >= WINDOW_END) begin
                knob_rate_next  = edge_count_reg;
                edge_count_next = '0;
                tick_count_next = '0;
            end else begin
                tick_count_next = tick_inc[TICK_W-1:0];
            end
        end else if (edge_en && edge_count_reg != EDGE_COUNT_MAX) begin
            // saturates at full scale
            edge_count_next = edge_count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg <= '0;
            edge_count_reg <= '0;
            knob_rate_reg  <= '0;
        end else begin
            tick_count_reg <= tick_count_next;
            edge_count_reg <= edge_count_next;
            knob_rate_reg  <= knob_rate_next;
        end
    end

    assign knob_rate = knob_rate_reg;

endmodule

`default_nettype wire

// ----- rtl/ksa_setpoint_unit.sv -----
// ---------------------------------------------------------------------------
// ksa_setpoint_unit
// Per-slot speed, temperature and time setpoints with step and clamp logic.
// ---------------------------------------------------------------------------
`default_nettype none

module ksa_setpoint_unit
    import ksa_pkg::*;
#(
    parameter int SLOTS      = 4,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  upd_en,
    input  wire logic [1:0]            slot,
    input  wire logic [1:0]            mode,
    input  wire logic                  dir,
    input  wire logic                  coarse,
    input  ksa_cfg_t                   cfg,
    output quantity_t                  quantity,
    output logic [VALUE_BITS-1:0]      new_value
);

    localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SWIDE_W = (SIDX_W > 2) ? SIDX_W : 2;
    // working width: covers value plus largest step, with a sign bit
    localparam int EW = ((VALUE_BITS > LIMIT_W) ? VALUE_BITS : LIMIT_W) + 2;

    logic [VALUE_BITS-1:0] speed_reg [SLOTS];
    logic [VALUE_BITS-1:0] temp_reg  [SLOTS];
    logic [VALUE_BITS-1:0] time_reg  [SLOTS];

    logic [SWIDE_W-1:0]     slot_wide;
    logic [SIDX_W-1:0]      idx;
    logic [VALUE_BITS-1:0]  cur;
    logic [LIMIT_W-1:0]     step16, hi16, lo16;
    logic signed [EW-1:0]   v, step, hi, lo, sum, diff, r;
    logic signed [EW-1:0]   top;
    logic [VALUE_BITS-1:0]  fit;

    assign slot_wide = SWIDE_W'(slot);
    assign idx       = slot_wide[SIDX_W-1:0];
    assign top       = {{(EW-VALUE_BITS){1'b0}}, {VALUE_BITS{1'b1}}};

    // Select quantity, current value, step and limits
    always_comb begin
        case (mode) inside
            MODE_SPEED_A, MODE_SPEED_B: begin
                quantity = QTY_SPEED;
                cur      = speed_reg[idx];
                step16   = coarse ? STEP_SPEED_COARSE : STEP_SPEED_FINE;
                hi16     = cfg.speed_ceil;
                lo16     = cfg.speed_floor;
            end
            MODE_TEMP: begin
                quantity = QTY_TEMP;
                cur      = temp_reg[idx];
                if (coarse) begin
                    step16 = STEP_TEMP_COARSE;
                end else if ({{(EW-VALUE_BITS){1'b0}}, temp_reg[idx]} <
                             {{(EW-LIMIT_W){1'b0}}, TEMP_BREAK}) begin
                    step16 = STEP_TEMP_LOW;
                end else begin
                    step16 = STEP_TEMP_HIGH;
                end
                hi16     = cfg.temp_ceil;
                lo16     = cfg.temp_floor;
            end
            default: begin
                quantity = QTY_TIME;
                cur      = time_reg[idx];
                step16   = coarse ? STEP_TIME_COARSE : STEP_TIME_FINE;
                hi16     = cfg.dur_ceil;
                lo16     = cfg.dur_floor;
            end
        endcase
    end

    assign v    = {{(EW-VALUE_BITS){1'b0}}, cur};
    assign step = {{(EW-LIMIT_W){1'b0}}, step16};
    assign hi   = {{(EW-LIMIT_W){1'b0}}, hi16};
    assign lo   = {{(EW-LIMIT_W){1'b0}}, lo16};
    assign sum  = v + step;
    assign diff = v - step;

    // Step and clamp
    always_comb begin
        if (quantity == QTY_SPEED) begin
            if (dir == DIR_INC) begin
                // a stopped speed jumps straight to the jump value
                r = (cur == '0) ? {{(EW-LIMIT_W){1'b0}}, SPEED_JUMP} : sum;
                if (r > hi) r = hi;
            end else begin
                r = (diff < lo) ? '0 : diff;
            end
        end else begin
            if (dir == DIR_INC) begin
                r = (sum > hi) ? hi : sum;
            end else begin
                r = (diff <= lo) ? lo : diff;
            end
        end
    end

    // Fit to the stored width
    always_comb begin
        if (r < 0) begin
            fit = '0;
        end else if (r > top) begin
            fit = {VALUE_BITS{1'b1}};
        end else begin
            fit = r[VALUE_BITS-1:0];
        end
    end

    assign new_value = fit;

    // Setpoint write-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                speed_reg[i] <= '0;
                temp_reg[i]  <= '0;
                time_reg[i]  <= '0;
            end
        end else if (upd_en) begin
            case (quantity)
                QTY_SPEED: speed_reg[idx] <= fit;
                QTY_TEMP:  temp_reg[idx]  <= fit;
                default:   time_reg[idx]  <= fit;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/knob_setpoint_adjuster_core.sv -----
// ---------------------------------------------------------------------------
// knob_setpoint_adjuster_core
// Knob rate measurement and per-slot setpoint stepping over stream ports.
// ---------------------------------------------------------------------------
// Path: an accepted item passes through the input register, then the result
//   register; ticks and out-of-range slots give no result.
// Throughput: one item per cycle while the result side is not stalled; the setpoint
//   read-modify-write of the slot table completes in the cycle between the two registers.
// Reset: synchronous, active low; clears counters, rate, all setpoints and
//   loads the default clamps and threshold. No clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module knob_setpoint_adjuster_core
    import ksa_pkg::*;
#(
    parameter int SLOTS            = 4,
    parameter int TICKS_PER_WINDOW = 100,
    parameter int VALUE_BITS       = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // direction, slot[1:0], mode[1:0], zeros
    input  wire logic [0:0]            s_tuser,   // op
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [23:0]                m_tdata,   // slot_out[1:0], new_value[15:0], coarse, zeros
    output logic [1:0]                 m_tuser    // quantity
);

    ksa_cfg_t cfg;

    logic       in_valid_reg, in_valid_next;
    logic       in_op_reg, in_dir_reg;
    logic [1:0] in_slot_reg, in_mode_reg;

    logic       m_tvalid_reg, m_tvalid_next;
    logic [1:0] out_slot_reg, out_qty_reg;
    logic [LIMIT_W-1:0] out_value_reg;
    logic       out_coarse_reg;

    logic [RATE_W-1:0]     knob_rate;
    logic                  coarse;
    logic                  slot_ok;
    logic                  has_result;
    logic                  out_free;
    logic                  adv;
    logic                  in_take;
    quantity_t             quantity;
    logic [VALUE_BITS-1:0] new_value;

    ksa_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Handshake and stage advance
    assign slot_ok    = ({30'd0, in_slot_reg} < 32'(SLOTS));
    assign has_result = (in_op_reg == OP_EDGE) && slot_ok;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign adv        = in_valid_reg && (!has_result || out_free);
    assign s_tready   = !in_valid_reg || adv;
    assign in_take    = s_tvalid && s_tready;
    assign coarse     = (knob_rate >= cfg.fast_threshold);

    ksa_rate_meter #(
        .TICKS_PER_WINDOW (TICKS_PER_WINDOW)
    ) u_rate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick_en   (adv && in_op_reg == OP_TICK),
        .edge_en   (adv && in_op_reg == OP_EDGE),
        .knob_rate (knob_rate)
    );

    ksa_setpoint_unit #(
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_setpt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .upd_en    (adv && has_result),
        .slot      (in_slot_reg),
        .mode      (in_mode_reg),
        .dir       (in_dir_reg),
        .coarse    (coarse),
        .cfg       (cfg),
        .quantity  (quantity),
        .new_value (new_value)
    );

    // Input register
    assign in_valid_next = in_take || (in_valid_reg && !adv);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_op_reg   <= s_tuser[0];
            in_dir_reg  <= s_tdata[0];
            in_slot_reg <= s_tdata[2:1];
            in_mode_reg <= s_tdata[4:3];
        end
    end

    // Result register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (adv && has_result) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && has_result) begin
            out_slot_reg   <= in_slot_reg;
            out_qty_reg    <= quantity;
            out_value_reg  <= LIMIT_W'(new_value);
            out_coarse_reg <= coarse;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_coarse_reg, out_value_reg, out_slot_reg};
    assign m_tuser  = out_qty_reg;

    // Checks
    `ASSERT_CLK(a_result_from_edge,
        $rose(m_tvalid_reg) |-> $past(adv && in_op_reg == OP_EDGE),
        "result raised without an advancing knob edge")
    `ASSERT_NEVER(a_no_overwrite,
        m_tvalid_reg && !m_tready && in_valid_reg && has_result && adv,
        "pending result would be overwritten")
    `ASSERT_CLK(a_ready_when_empty,
        !in_valid_reg |-> s_tready,
        "input refused while input register is empty")

endmodule

`default_nettype wire

// ----- test/knob_setpoint_adjuster_core_tb.sv -----
// ----------------------------------------------------------------------------
// knob_setpoint_adjuster_core_tb
// Drives ticks and knob edges into the setpoint adjuster and checks every
// setpoint update against an in-bench prediction of knob rate, step size
// and clamping. Several limit settings are applied between quiet phases.
// ----------------------------------------------------------------------------
module knob_setpoint_adjuster_core_tb;
    import ksa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD       = 10;
    localparam int NUM_SLOTS        = 4;
    localparam int TICKS_PER_WINDOW = 100;
    localparam int VAL_BITS         = 16;
    localparam int SETTLE_CYCLES    = 4;
    localparam int HOLD_CYCLES      = 200;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int MAX_REPORTS      = 30;

    // step sizes and special values, as specified
    localparam longint SPD_FINE    = 10;
    localparam longint SPD_COARSE  = 30;
    localparam longint TMP_LOW     = 5;
    localparam longint TMP_HIGH    = 10;
    localparam longint TMP_COARSE  = 20;
    localparam longint TIM_FINE    = 60;
    localparam longint TIM_COARSE  = 300;
    localparam longint SPD_JUMP    = 100;
    localparam longint TMP_BREAK   = 1000;
    localparam longint VALUE_TOP   = (longint'(1) << VAL_BITS) - 1;

    typedef struct packed {
        logic [1:0]  slot;
        quantity_t   qty;
        logic [15:0] value;
        logic        coarse;
    } setpoint_update_t;

    // ------------------------------------------------------------------------
    // Setpoint tracker: predicts updates and checks them in order
    // ------------------------------------------------------------------------
    class setpoint_tracker;
        logic [15:0] speed_ceil, speed_floor, temp_ceil, temp_floor, dur_ceil, dur_floor;
        logic [7:0]  fast_thr;
        logic [7:0]  edge_count, knob_rate;
        logic [6:0]  tick_count;
        logic [15:0] speed_sp[NUM_SLOTS];
        logic [15:0] temp_sp[NUM_SLOTS];
        logic [15:0] time_sp[NUM_SLOTS];
        setpoint_update_t awaited_updates[$];
        int n_errors, n_checked, n_ticks, n_edges, n_coarse;

        function new();
            speed_ceil  = 16'd1500;
            speed_floor = 16'd100;
            temp_ceil   = 16'd3500;
            temp_floor  = 16'd0;
            dur_ceil    = 16'd35940;
            dur_floor   = 16'd0;
            fast_thr    = 8'd10;
            edge_count  = '0;
            knob_rate   = '0;
            tick_count  = '0;
            foreach (speed_sp[i]) begin
                speed_sp[i] = '0;
                temp_sp[i]  = '0;
                time_sp[i]  = '0;
            end
            n_errors  = 0;
            n_checked = 0;
            n_ticks   = 0;
            n_edges   = 0;
            n_coarse  = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [15:0] val);
            case (idx)
                REG_SPEED_MAX:      speed_ceil  = val;
                REG_SPEED_MIN:      speed_floor = val;
                REG_TEMP_MAX:       temp_ceil   = val;
                REG_TEMP_MIN:       temp_floor  = val;
                REG_TIME_MAX:       dur_ceil    = val;
                REG_TIME_MIN:       dur_floor   = val;
                REG_FAST_THRESHOLD: fast_thr    = val[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited_updates.size();
        endfunction

        function int ticks_to_window();
            return TICKS_PER_WINDOW - int'(tick_count);
        endfunction

        // one accepted input item
        function void note_knob_item(logic op, logic dir, logic [1:0] slot, logic [1:0] mode);
            int unsigned t;
            longint v, step, hi, lo;
            logic coarse;
            setpoint_update_t upd;
            if (op == OP_TICK) begin
                n_ticks++;
                t = tick_count + 1;
                if (t >= TICKS_PER_WINDOW) begin
                    knob_rate  = edge_count;
                    edge_count = '0;
                    t = 0;
                end
                tick_count = t[6:0];
                return;
            end
            n_edges++;
            if (edge_count != 8'd255)
                edge_count++;
            if (slot >= NUM_SLOTS)
                return;
            coarse = (knob_rate >= fast_thr);
            case (mode) inside
                MODE_SPEED_A, MODE_SPEED_B: begin
                    upd.qty = QTY_SPEED;
                    v    = speed_sp[slot];
                    step = coarse ? SPD_COARSE : SPD_FINE;
                    hi   = speed_ceil;
                    lo   = speed_floor;
                    if (dir == DIR_INC) begin
                        v += step;
                        // a stopped speed starts at the jump value
                        if (v == step)
                            v = SPD_JUMP;
                        if (v > hi)
                            v = hi;
                    end else begin
                        v -= step;
                        if (v < lo)
                            v = 0;
                    end
                end
                default: begin
                    if (mode == MODE_TEMP) begin
                        upd.qty = QTY_TEMP;
                        v    = temp_sp[slot];
                        step = coarse ? TMP_COARSE : (v < TMP_BREAK ? TMP_LOW : TMP_HIGH);
                        hi   = temp_ceil;
                        lo   = temp_floor;
                    end else begin
                        upd.qty = QTY_TIME;
                        v    = time_sp[slot];
                        step = coarse ? TIM_COARSE : TIM_FINE;
                        hi   = dur_ceil;
                        lo   = dur_floor;
                    end
                    if (dir == DIR_INC) begin
                        v += step;
                        if (v > hi)
                            v = hi;
                    end else begin
                        v -= step;
                        if (v <= lo)
                            v = lo;
                    end
                end
            endcase
            // stored values saturate to the value range
            if (v < 0)
                v = 0;
            if (v > VALUE_TOP)
                v = VALUE_TOP;
            case (upd.qty)
                QTY_SPEED: speed_sp[slot] = v[15:0];
                QTY_TEMP:  temp_sp[slot]  = v[15:0];
                default:   time_sp[slot]  = v[15:0];
            endcase
            upd.slot   = slot;
            upd.value  = v[15:0];
            upd.coarse = coarse;
            if (coarse)
                n_coarse++;
            awaited_updates.push_back(upd);
        endfunction

        // one accepted result item
        function void check_update(logic [23:0] data, logic [1:0] user);
            setpoint_update_t exp_upd;
            setpoint_update_t got;
            got.slot   = data[1:0];
            got.value  = data[17:2];
            got.coarse = data[18];
            got.qty    = quantity_t'(user);
            if (awaited_updates.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: unexpected update slot=%0d qty=%0d value=%0d coarse=%0d",
                             $time, got.slot, got.qty, got.value, got.coarse);
                return;
            end
            exp_upd = awaited_updates.pop_front();
            n_checked++;
            if (got.slot !== exp_upd.slot || got.qty !== exp_upd.qty ||
                got.value !== exp_upd.value || got.coarse !== exp_upd.coarse ||
                data[23:19] !== 5'd0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: update mismatch, expected slot=%0d qty=%0d value=%0d coarse=%0d, actual slot=%0d qty=%0d value=%0d coarse=%0d pad=%b",
                             $time, exp_upd.slot, exp_upd.qty, exp_upd.value, exp_upd.coarse,
                             got.slot, got.qty, got.value, got.coarse, data[23:19]);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;    // direction, slot[1:0], mode[1:0], zeros
    logic [0:0]            s_tuser;    // op
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;    // slot_out[1:0], new_value[15:0], coarse, zeros
    logic [1:0]            m_tuser;    // quantity

    setpoint_tracker board;
    bit  hold_req;
    bit  no_idle;
    int  n_settings;
    int  cycle_count;
    int  stall_left;

    knob_setpoint_adjuster_core #(
        .SLOTS           (NUM_SLOTS),
        .TICKS_PER_WINDOW(TICKS_PER_WINDOW),
        .VALUE_BITS      (VAL_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stalls plus the long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = HOLD_CYCLES;
        end else if (stall_left == 0 && !no_idle && $urandom_range(0, 99) < 25) begin
            stall_left = pick_gap();
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_update(m_tdata, m_tuser);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("** knob_setpoint_adjuster_core: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    task automatic send_item(logic op, logic dir, logic [1:0] slot, logic [1:0] mode);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, mode, slot, dir};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        board.note_knob_item(op, dir, slot, mode);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic send_random(int edge_pct, int inc_pct, output logic was_edge);
        logic op, dir;
        op  = ($urandom_range(0, 99) < edge_pct) ? OP_EDGE : OP_TICK;
        dir = ($urandom_range(0, 99) < inc_pct) ? DIR_INC : DIR_DEC;
        send_item(op, dir, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
        was_edge = (op == OP_EDGE);
    endtask

    // random traffic until enough knob edges have gone in
    task automatic run_traffic(int edges_wanted, int edge_pct, int inc_pct);
        int   sent;
        logic was_edge;
        sent = 0;
        while (sent < edges_wanted) begin
            send_random(edge_pct, inc_pct, was_edge);
            if (was_edge)
                sent++;
        end
    endtask

    // stop sending, let every update drain, then allow the pipeline to empty
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        board.set_reg(idx, val);
    endtask

    task automatic apply_limits(logic [15:0] spd_hi, logic [15:0] spd_lo,
                                logic [15:0] tmp_hi, logic [15:0] tmp_lo,
                                logic [15:0] tim_hi, logic [15:0] tim_lo,
                                logic [7:0] thr);
        write_reg(REG_SPEED_MAX, spd_hi);
        write_reg(REG_SPEED_MIN, spd_lo);
        write_reg(REG_TEMP_MAX, tmp_hi);
        write_reg(REG_TEMP_MIN, tmp_lo);
        write_reg(REG_TIME_MAX, tim_hi);
        write_reg(REG_TIME_MIN, tim_lo);
        write_reg(REG_FAST_THRESHOLD, {8'd0, thr});
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int closing;
        board       = new();
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        hold_req    = 1'b0;
        no_idle     = 1'b0;
        n_settings  = 1;
        cycle_count = 0;
        stall_left  = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset limits, fine steps, jump, floors and ignored tick fields
        send_item(OP_EDGE, DIR_INC, 2'd0, MODE_SPEED_A);   // 0 jumps to 100
        send_item(OP_EDGE, DIR_INC, 2'd0, MODE_SPEED_B);   // 110
        send_item(OP_EDGE, DIR_DEC, 2'd0, MODE_SPEED_A);   // down to the minimum
        send_item(OP_EDGE, DIR_DEC, 2'd0, MODE_SPEED_B);   // below minimum: stop
        send_item(OP_EDGE, DIR_DEC, 2'd0, MODE_SPEED_A);   // already stopped
        send_item(OP_EDGE, DIR_INC, 2'd3, MODE_TEMP);
        send_item(OP_EDGE, DIR_DEC, 2'd3, MODE_TEMP);
        send_item(OP_EDGE, DIR_DEC, 2'd3, MODE_TEMP);      // floor at the minimum
        send_item(OP_EDGE, DIR_INC, 2'd2, MODE_TIME);
        send_item(OP_EDGE, DIR_INC, 2'd2, MODE_TIME);
        send_item(OP_EDGE, DIR_DEC, 2'd2, MODE_TIME);
        send_item(OP_TICK, DIR_DEC, 2'd3, MODE_TIME);      // fields ignored on a tick
        send_item(OP_TICK, DIR_INC, 2'd1, MODE_SPEED_B);
        send_item(OP_EDGE, DIR_INC, 2'd1, MODE_SPEED_B);
        send_item(OP_EDGE, DIR_INC, 2'd2, MODE_SPEED_A);
        send_item(OP_EDGE, DIR_INC, 2'd3, MODE_SPEED_A);
        send_item(OP_EDGE, DIR_INC, 2'd1, MODE_TEMP);
        send_item(OP_EDGE, DIR_DEC, 2'd0, MODE_TIME);
        send_item(OP_EDGE, DIR_INC, 2'd0, MODE_TIME);
        send_item(OP_TICK, DIR_DEC, 2'd2, MODE_TEMP);
        settle();

        // temperature floor just under the step break, rate near threshold
        apply_limits(16'd1500, 16'd100, 16'd3500, 16'd995, 16'd35940, 16'd0, 8'd10);
        run_traffic(25, 15, 60);
        settle();

        // widest limits, always coarse; result side holds off at the start
        apply_limits(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 8'd0);
        hold_req = 1'b1;
        run_traffic(60, 50, 80);
        settle();

        // minimum above maximum, top threshold, edge counter driven to saturation
        apply_limits(16'd50, 16'd2000, 16'd10, 16'd60000, 16'd0, 16'hFFFF, 8'd255);
        run_traffic(260, 100, 50);
        closing = board.ticks_to_window();
        repeat (closing)
            send_item(OP_TICK, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                      2'($urandom_range(0, 3)));
        run_traffic(20, 50, 50);
        settle();

        // random small limits so clamps are hit often
        apply_limits(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 1500)),
                     16'($urandom_range(0, 2000)), 16'($urandom_range(0, 1500)),
                     16'($urandom_range(0, 2000)), 16'($urandom_range(0, 1500)),
                     8'($urandom_range(0, 30)));
        run_traffic(30, 40, 50);
        settle();

        // limits at the top of the range, back-to-back traffic on both sides
        apply_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd65500, 16'hFFFF, 16'd65400, 8'd0);
        no_idle = 1'b1;
        run_traffic(30, 50, 50);
        settle();
        no_idle = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d ticks and %0d knob edges under %0d limit settings;",
                 board.n_ticks, board.n_edges, n_settings);
        $display("%0d setpoint updates checked, %0d of them with coarse steps.",
                 board.n_checked, board.n_coarse);
        if (board.n_errors == 0) begin
            $display("** knob_setpoint_adjuster_core: PASSED **");
        end else begin
            $display("** knob_setpoint_adjuster_core: FAILED **");
        end
        $finish;
    end

endmodule
